// ===== design/bfla_pkg.sv =====
package bfla_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W      = CNT_W + 2;

    localparam logic [CNT_W-1:0] NONE_IDX = CNT_W'(MAX_BLOCKS);

    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_ALLOC   = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_DEALLOC = 3'd3;
    localparam logic [2:0] CMD_PURGE   = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_SHORT   = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    localparam int          REG_BLOCKS_IN_USE = 0;
    localparam logic [8:0]  BLOCKS_IN_USE_RST = 9'd256;

    typedef struct packed {
        logic [2:0]       command;
        logic [CNT_W-1:0] block_count;
        logic [IDX_W-1:0] first_block;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] block_index;
        logic [CNT_W-1:0] chain_length;
        logic [CNT_W-1:0] available_count;
        logic [CNT_W-1:0] released_count;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic start;
        logic walk;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic       alloc_walk;
        logic       first_ok;
        logic       walk_end;
    } dp_stat_t;

endpackage

// ===== design/bfla_dp.sv =====
module bfla_dp import bfla_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          ctl,
    output dp_stat_t         stat,
    input  in_word_t         cmd_word,
    input  logic [8:0]       blocks_in_use,
    output out_word_t        res_word
);

    logic [CNT_W-1:0]      next_index_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] vld_reg;

    in_word_t         in_reg;
    out_word_t        res_reg;
    logic [CNT_W-1:0] page_reg;
    logic [CNT_W-1:0] avail_head_reg;
    logic [CNT_W-1:0] avail_total_reg;
    logic [CNT_W-1:0] rel_head_reg;
    logic [CNT_W-1:0] rel_tail_reg;
    logic [CNT_W-1:0] rel_total_reg;
    logic [CNT_W-1:0] last_reg;
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] nxt_reg;
    logic             ended_reg;
    logic [CNT_W-1:0] rd_addr_reg;
    logic [CNT_W-1:0] rd_data_reg;
    logic             rd_vld_reg;

    logic [CNT_W-1:0] page_next;
    logic [CNT_W-1:0] avail_head_next;
    logic [CNT_W-1:0] avail_total_next;
    logic [CNT_W-1:0] rel_head_next;
    logic [CNT_W-1:0] rel_tail_next;
    logic [CNT_W-1:0] rel_total_next;
    out_word_t        res_next;

    logic [CNT_W-1:0] nv;
    logic [CNT_W-1:0] dflt;
    logic [CNT_W-1:0] start_addr;
    logic [CNT_W-1:0] rd_addr;
    logic [CNT_W-1:0] clamp_n;
    logic [SUM_W-1:0] fill_sum;
    logic             clr_all;
    logic             we;
    logic [CNT_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic             walk_end_alloc;
    logic             walk_end_chain;

    // untouched entries follow the page chain
    assign dflt = ((CNT_W'(rd_addr_reg[IDX_W-1:0]) + CNT_W'(1)) < page_reg)
                  ? CNT_W'(rd_addr_reg[IDX_W-1:0]) + CNT_W'(1) : NONE_IDX;

    assign nv = (rd_addr_reg >= NONE_IDX) ? NONE_IDX
              : (rd_vld_reg ? rd_data_reg : dflt);

    assign start_addr = (in_reg.command == CMD_ALLOC) ? avail_head_reg
                                                      : CNT_W'(in_reg.first_block);

    assign walk_end_alloc = (len_reg == in_reg.block_count);
    assign walk_end_chain = (nv == NONE_IDX) || (len_reg >= CNT_W'(MAX_BLOCKS));

    assign stat.command    = in_reg.command;
    assign stat.alloc_walk = (in_reg.block_count != '0)
                             && (in_reg.block_count <= avail_total_reg);
    assign stat.first_ok   = (CNT_W'(in_reg.first_block) < NONE_IDX);
    assign stat.walk_end   = (in_reg.command == CMD_ALLOC) ? walk_end_alloc
                                                           : walk_end_chain;

    always_comb
    begin
        if (ctl.start)
        begin
            rd_addr = start_addr;
        end
        else if (ctl.walk)
        begin
            rd_addr = nv;
        end
        else
        begin
            rd_addr = last_reg;
        end
    end

    always_comb
    begin
        if (blocks_in_use == '0)
        begin
            clamp_n = CNT_W'(1);
        end
        else if (CNT_W'(blocks_in_use) > NONE_IDX)
        begin
            clamp_n = NONE_IDX;
        end
        else
        begin
            clamp_n = CNT_W'(blocks_in_use);
        end
    end

    assign fill_sum = SUM_W'(avail_total_reg) + SUM_W'(rel_total_reg) + SUM_W'(len_reg);

    always_comb
    begin
        page_next         = page_reg;
        avail_head_next   = avail_head_reg;
        avail_total_next  = avail_total_reg;
        rel_head_next     = rel_head_reg;
        rel_tail_next     = rel_tail_reg;
        rel_total_next    = rel_total_reg;
        clr_all           = 1'b0;
        we                = 1'b0;
        waddr             = last_reg;
        wdata             = NONE_IDX;
        res_next.status       = STAT_OK;
        res_next.block_index  = NONE_IDX;
        res_next.chain_length = '0;
        case (in_reg.command)
            CMD_INIT:
            begin
                page_next        = clamp_n;
                clr_all          = 1'b1;
                avail_head_next  = '0;
                avail_total_next = clamp_n;
                rel_head_next    = NONE_IDX;
                rel_tail_next    = NONE_IDX;
                rel_total_next   = '0;
            end
            CMD_ALLOC:
            begin
                if (in_reg.block_count > avail_total_reg)
                begin
                    res_next.status = STAT_SHORT;
                end
                else if (in_reg.block_count != '0)
                begin
                    res_next.block_index = avail_head_reg;
                    avail_total_next     = avail_total_reg - in_reg.block_count;
                    avail_head_next      = (avail_total_next == '0) ? NONE_IDX : nxt_reg;
                    we                   = (last_reg < NONE_IDX);
                    waddr                = last_reg;
                    wdata                = NONE_IDX;
                end
            end
            CMD_RELEASE, CMD_DEALLOC:
            begin
                if (CNT_W'(in_reg.first_block) >= NONE_IDX)
                begin
                    res_next.status = STAT_REFUSED;
                end
                else
                begin
                    res_next.chain_length = len_reg;
                    if (!ended_reg || (fill_sum > SUM_W'(page_reg)))
                    begin
                        res_next.status = STAT_REFUSED;
                    end
                    else if (in_reg.command == CMD_RELEASE)
                    begin
                        rel_total_next = rel_total_reg + len_reg;
                        if (rel_tail_reg == NONE_IDX)
                        begin
                            rel_tail_next = last_reg;
                        end
                        we            = (last_reg < NONE_IDX);
                        waddr         = last_reg;
                        wdata         = rel_head_reg;
                        rel_head_next = CNT_W'(in_reg.first_block);
                    end
                    else
                    begin
                        avail_total_next = avail_total_reg + len_reg;
                        we               = (last_reg < NONE_IDX);
                        waddr            = last_reg;
                        wdata            = avail_head_reg;
                        avail_head_next  = CNT_W'(in_reg.first_block);
                    end
                end
            end
            CMD_PURGE:
            begin
                if (rel_head_reg != NONE_IDX)
                begin
                    we               = (rel_tail_reg < NONE_IDX);
                    waddr            = rel_tail_reg;
                    wdata            = avail_head_reg;
                    avail_head_next  = rel_head_reg;
                    rel_head_next    = NONE_IDX;
                    rel_tail_next    = NONE_IDX;
                    avail_total_next = avail_total_reg + rel_total_reg;
                    rel_total_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
        res_next.available_count = avail_total_next;
        res_next.released_count  = rel_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg        <= NONE_IDX;
            avail_head_reg  <= '0;
            avail_total_reg <= NONE_IDX;
            rel_head_reg    <= NONE_IDX;
            rel_tail_reg    <= NONE_IDX;
            rel_total_reg   <= '0;
            vld_reg         <= '0;
        end
        else if (ctl.commit)
        begin
            page_reg        <= page_next;
            avail_head_reg  <= avail_head_next;
            avail_total_reg <= avail_total_next;
            rel_head_reg    <= rel_head_next;
            rel_tail_reg    <= rel_tail_next;
            rel_total_reg   <= rel_total_next;
            if (clr_all)
            begin
                vld_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[waddr[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && we)
        begin
            next_index_mem[waddr[IDX_W-1:0]] <= wdata;
        end
        rd_data_reg <= next_index_mem[rd_addr[IDX_W-1:0]];
        rd_vld_reg  <= vld_reg[rd_addr[IDX_W-1:0]];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_reg <= cmd_word;
        end
        if (ctl.start)
        begin
            last_reg <= start_addr;
            len_reg  <= CNT_W'(1);
        end
        else if (ctl.walk)
        begin
            if (stat.walk_end)
            begin
                nxt_reg   <= nv;
                ended_reg <= (nv == NONE_IDX);
            end
            else
            begin
                last_reg <= nv;
                len_reg  <= len_reg + CNT_W'(1);
            end
        end
        if (ctl.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_word = res_reg;

endmodule

// ===== design/bfla_ctrl.sv =====
module bfla_ctrl import bfla_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    output logic     res_valid,
    input  logic     res_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   stall_reg;
    logic   out_valid_reg;
    logic   go_walk;

    always_comb
    begin
        if (stat.command == CMD_ALLOC)
        begin
            go_walk = stat.alloc_walk;
        end
        else if (stat.command inside {CMD_RELEASE, CMD_DEALLOC})
        begin
            go_walk = stat.first_ok;
        end
        else
        begin
            go_walk = 1'b0;
        end
    end

    assign ctl.load   = cmd_valid && !stall_reg;
    assign ctl.start  = (state_reg == S_DECIDE) && go_walk;
    assign ctl.walk   = (state_reg == S_WALK);
    assign ctl.commit = (state_reg == S_FINISH) && (!out_valid_reg || !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stall_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (ctl.load)
                    begin
                        stall_reg <= 1'b1;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= go_walk ? S_WALK : S_FINISH;
                end
                S_WALK:
                begin
                    if (stat.walk_end)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (ctl.commit)
                    begin
                        stall_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_stall = stall_reg;
    assign res_valid = out_valid_reg;

endmodule

// ===== design/block_free_list_allocator_unit.sv =====
// Free-list allocator for one page of up to 256 equal blocks.
// Command channel: cmd_valid / cmd_stall / cmd_word (command, block_count,
// first_block); a word is taken when cmd_valid is high and cmd_stall low.
// Result channel: res_valid / res_stall / res_word, exactly one result word
// per command word.
// From the accepting edge the controller decides, walks the next-index
// memory when needed (allocate walks its N blocks; release and deallocate
// walk the chain, stopping at 256 blocks), then loads the result into the
// output register; init, purge, short or empty allocate skip the walk.
// The walk goes one link per cycle; one command is in flight at a time, so
// a new word is taken the cycle after the previous result is registered.
// A stalled result holds in the output register; the block still takes the
// next command and stalls it only at the end of its work.
// Reset chains all 256 blocks into the available list at once through
// per-entry valid bits, and sets blocks_in_use to 256.
// APB register 0 (address 0): blocks_in_use, latched into the page size by
// the init command. Write it only while no command is in flight.
module block_free_list_allocator_unit import bfla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  in_word_t    cmd_word,
    output logic        res_valid,
    input  logic        res_stall,
    output out_word_t   res_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0] blocks_in_use_reg;
    logic       reg_hit;
    dp_cmd_t    ctl;
    dp_stat_t   stat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'(REG_BLOCKS_IN_USE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= BLOCKS_IN_USE_RST;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            blocks_in_use_reg <= pwdata[8:0];
        end
    end

    assign prdata = reg_hit ? {23'd0, blocks_in_use_reg} : 32'd0;

    bfla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    bfla_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd_word      (cmd_word),
        .blocks_in_use (blocks_in_use_reg),
        .res_word      (res_word)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while another is in flight");

    a_result_follows_command: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall))
        else $error("result without a command in flight");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((10'(res_word.available_count) + 10'(res_word.released_count))
                       <= 10'(MAX_BLOCKS)))
        else $error("block counts exceed the page");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import bfla_pkg::*;

    localparam logic [2:0] CMD_UNKNOWN_LO = CMD_PURGE + 3'd1;
    localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
    localparam int         MAX_COUNT      = (1 << CNT_W) - 1;
    localparam int         MAX_FIRST      = (1 << IDX_W) - 1;
    localparam int         REPORT_CAP     = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    in_word_t    cmd_word = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    out_word_t   res_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct = 38;
    int mismatches = 0;
    int words_sent = 0;
    int results_checked = 0;
    int refusals = 0;
    int endless_walks = 0;
    int pages_tried = 0;

    out_word_t pending_results[$];
    int        owned_chains[$];

    // page state as seen from outside
    logic [CNT_W-1:0] link_mem [MAX_BLOCKS];
    int avail_head, avail_total, rel_head, rel_tail, rel_total, page_size, blocks_reg;

    block_free_list_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic int link_of(int i);
        return (i < MAX_BLOCKS) ? int'(link_mem[i]) : MAX_BLOCKS;
    endfunction

    function automatic void set_link(int i, int v);
        if (i < MAX_BLOCKS)
            link_mem[i] = CNT_W'(v);
    endfunction

    function automatic void chain_page();
        int n;
        n = blocks_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_BLOCKS)
            n = MAX_BLOCKS;
        page_size = n;
        for (int i = 0; i < MAX_BLOCKS; i++)
            link_mem[i] = (i + 1 < n) ? CNT_W'(i + 1) : NONE_IDX;
        avail_head  = 0;
        avail_total = n;
        rel_head    = MAX_BLOCKS;
        rel_tail    = MAX_BLOCKS;
        rel_total   = 0;
    endfunction

    function automatic out_word_t apply_command(in_word_t w);
        out_word_t r;
        int cnt, first, last, len, status, bidx, clen;
        bit ended;
        cnt    = int'(w.block_count);
        first  = int'(w.first_block);
        status = STAT_OK;
        bidx   = MAX_BLOCKS;
        clen   = 0;
        case (w.command)
            CMD_INIT:
                chain_page();
            CMD_ALLOC:
                if (cnt > avail_total)
                    status = STAT_SHORT;
                else if (cnt > 0)
                begin
                    last = avail_head;
                    for (int i = 0; i + 1 < cnt; i++)
                        last = link_of(last);
                    bidx = avail_head;
                    avail_head = link_of(last);
                    set_link(last, MAX_BLOCKS);
                    avail_total -= cnt;
                    if (avail_total == 0)
                        avail_head = MAX_BLOCKS;
                end
            CMD_RELEASE, CMD_DEALLOC:
            begin
                last  = first;
                len   = 1;
                ended = 1'b1;
                while (link_of(last) != MAX_BLOCKS)
                begin
                    if (len >= MAX_BLOCKS)
                    begin
                        ended = 1'b0;
                        break;
                    end
                    len++;
                    last = link_of(last);
                end
                clen = len;
                if (!ended || avail_total + rel_total + len > page_size)
                    status = STAT_REFUSED;
                else if (w.command == CMD_RELEASE)
                begin
                    rel_total += len;
                    if (rel_tail == MAX_BLOCKS)
                        rel_tail = last;
                    set_link(last, rel_head);
                    rel_head = first;
                end
                else
                begin
                    avail_total += len;
                    set_link(last, avail_head);
                    avail_head = first;
                end
            end
            CMD_PURGE:
                if (rel_head != MAX_BLOCKS)
                begin
                    set_link(rel_tail, avail_head);
                    avail_head  = rel_head;
                    rel_head    = MAX_BLOCKS;
                    rel_tail    = MAX_BLOCKS;
                    avail_total += rel_total;
                    rel_total   = 0;
                end
            default: ;
        endcase
        r.status          = 2'(status);
        r.block_index     = CNT_W'(bidx);
        r.chain_length    = CNT_W'(clen);
        r.available_count = CNT_W'(avail_total);
        r.released_count  = CNT_W'(rel_total);
        return r;
    endfunction

    function automatic in_word_t pack_cmd(logic [2:0] c, int count, int first);
        in_word_t w;
        w.command     = c;
        w.block_count = CNT_W'(count);
        w.first_block = IDX_W'(first);
        return w;
    endfunction

    task automatic report_mismatch(input string why, input out_word_t got,
                                   input out_word_t want);
        if (mismatches < REPORT_CAP)
        begin
            $write("%0t MISMATCH %s: got st=%0d idx=%0d len=%0d av=%0d rel=%0d",
                   $time, why, got.status, got.block_index, got.chain_length,
                   got.available_count, got.released_count);
            $display(", want st=%0d idx=%0d len=%0d av=%0d rel=%0d",
                     want.status, want.block_index, want.chain_length,
                     want.available_count, want.released_count);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result word with nothing pending", res_word, '0);
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (res_word.status !== want.status
                    || res_word.block_index !== want.block_index
                    || res_word.chain_length !== want.chain_length
                    || res_word.available_count !== want.available_count
                    || res_word.released_count !== want.released_count)
                    report_mismatch("result word differs", res_word, want);
            end
        end
    end

    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < idle_pct);

    task automatic issue(input in_word_t w, output out_word_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd_word  = w;
        do
            @(posedge clk);
        while (cmd_stall);
        want = apply_command(w);
        pending_results.push_back(want);
        words_sent++;
        if (want.status != STAT_OK)
            refusals++;
        if (want.status == STAT_REFUSED && want.chain_length == CNT_W'(MAX_BLOCKS))
            endless_walks++;
    endtask

    task automatic settle();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_blocks_in_use(input int value);
        settle();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(4 * REG_BLOCKS_IN_USE);
        pwdata  = 32'(value & MAX_COUNT);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        blocks_reg = int'(pwdata[CNT_W-1:0]);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic test_reset_state();
        out_word_t r;
        issue(pack_cmd(CMD_PURGE, 0, 0), r);
        issue(pack_cmd(CMD_ALLOC, 0, MAX_FIRST), r);
        issue(pack_cmd(CMD_UNKNOWN_LO, 1, 0), r);
        issue(pack_cmd(CMD_UNKNOWN_HI, MAX_COUNT, MAX_FIRST), r);
        issue(pack_cmd(CMD_ALLOC, MAX_COUNT, 0), r);
    endtask

    task automatic test_alloc_release();
        out_word_t r;
        issue(pack_cmd(CMD_ALLOC, MAX_BLOCKS, 0), r);
        issue(pack_cmd(CMD_ALLOC, 1, 0), r);
        issue(pack_cmd(CMD_RELEASE, 0, 0), r);
        issue(pack_cmd(CMD_PURGE, 0, 0), r);
        issue(pack_cmd(CMD_ALLOC, 3, 0), r);
        issue(pack_cmd(CMD_RELEASE, 0, 0), r);
        issue(pack_cmd(CMD_DEALLOC, 0, 5), r);
        issue(pack_cmd(CMD_RELEASE, 0, 0), r);
        issue(pack_cmd(CMD_PURGE, 0, 0), r);
        issue(pack_cmd(CMD_ALLOC, 2, 0), r);
        issue(pack_cmd(CMD_DEALLOC, 0, 0), r);
    endtask

    // close the available list on itself, then walk the loop
    task automatic test_endless_chain();
        out_word_t r;
        issue(pack_cmd(CMD_INIT, 0, 0), r);
        issue(pack_cmd(CMD_ALLOC, 200, 0), r);
        issue(pack_cmd(CMD_DEALLOC, 0, 250), r);
        issue(pack_cmd(CMD_RELEASE, 0, 200), r);
        issue(pack_cmd(CMD_ALLOC, 60, 0), r);
    endtask

    task automatic random_traffic(input int n);
        out_word_t  r;
        logic [2:0] c;
        int pick, count, first, pos;
        issue(pack_cmd(CMD_INIT, $urandom_range(0, MAX_COUNT), $urandom_range(0, MAX_FIRST)), r);
        owned_chains.delete();
        for (int k = 0; k < n; k++)
        begin
            pick  = $urandom_range(0, 99);
            count = $urandom_range(0, MAX_COUNT);
            first = $urandom_range(0, MAX_FIRST);
            c     = CMD_ALLOC;
            if (pick < 3)
                c = CMD_INIT;
            else if (pick < 75 && (pick < 40 || owned_chains.size() == 0))
            begin
                pos = $urandom_range(0, 9);
                if (pos < 7)
                    count = $urandom_range(1, 8);
                else if (pos < 9)
                    count = $urandom_range(0, avail_total + 2);
            end
            else if (pick < 75)
            begin
                pos = $urandom_range(0, owned_chains.size() - 1);
                first = owned_chains[pos];
                owned_chains.delete(pos);
                c = (pick < 60) ? CMD_RELEASE : CMD_DEALLOC;
            end
            else if (pick < 85)
                c = CMD_PURGE;
            else if (pick < 93)
                c = $urandom_range(0, 1) ? CMD_RELEASE : CMD_DEALLOC;
            else
                c = 3'($urandom_range(0, CMD_UNKNOWN_HI));
            issue(pack_cmd(c, count, first), r);
            if (c == CMD_INIT)
                owned_chains.delete();
            else if (c == CMD_ALLOC && r.block_index != NONE_IDX)
                owned_chains.push_back(int'(r.block_index));
        end
    endtask

    task automatic test_page_sizes();
        int sizes[7];
        sizes = '{0, 1, 2, MAX_COUNT, MAX_BLOCKS, 17, $urandom_range(1, 300)};
        foreach (sizes[i])
        begin
            write_blocks_in_use(sizes[i]);
            pages_tried++;
            random_traffic(110);
        end
    endtask

    task automatic test_no_idle();
        settle();
        idle_pct = 0;
        write_blocks_in_use(MAX_BLOCKS);
        random_traffic(160);
        settle();
        idle_pct = 38;
    endtask

    initial
    begin
        blocks_reg = int'(BLOCKS_IN_USE_RST);
        chain_page();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_alloc_release();
        test_endless_chain();
        test_page_sizes();
        test_no_idle();

        settle();
        repeat (270) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("result word never arrived", '0, pending_results[0]);
        $display("Sent %0d command words over %0d page sizes: %0d refused, %0d endless walks",
                 words_sent, pages_tried + 1, refusals, endless_walks);
        $display("Checked %0d result words, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
